### src/lazy_segment_tree_range_add_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lazy segment tree block
// Clocked assertions with reset disable, used by the checker file.
// ----------------------------------------------------------------------------
`ifndef LAZY_SEGMENT_TREE_RANGE_ADD_MACROS_SVH
`define LAZY_SEGMENT_TREE_RANGE_ADD_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off during reset.
`define LST_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// A signal keeps its value in the cycle after a condition holds.
`define LST_ASSERT_STABLE(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

### src/lst_pkg.sv
// ----------------------------------------------------------------------------
// Lazy segment tree package
// Shared sizes, request codes and the structs between the walker and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package lst_pkg;

  localparam int NUM_ELEMENTS = 1024;
  localparam int IDX_W        = 10;
  localparam int CNT_W        = 11;
  localparam int VAL_W        = 32;
  localparam int DATA_W       = 64;
  localparam int TREE_SLOTS   = 2048;
  localparam int ADDR_W       = 11;
  localparam int STACK_D      = 10;
  localparam int LVL_W        = 4;
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(NUM_ELEMENTS);

  typedef enum logic [1:0] {
    REQ_SET = 2'd0,
    REQ_ADD = 2'd1,
    REQ_SUM = 2'd2
  } req_e;

  typedef struct packed {
    req_e              kind;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [DATA_W-1:0] val;
    logic [IDX_W-1:0]  last;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic              sum_we;
    logic [DATA_W-1:0] sum_wd;
    logic              pend_we;
    logic [DATA_W-1:0] pend_wd;
  } mem_req_t;

endpackage

`default_nettype wire

### src/lst_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### src/lst_walk.sv
// ----------------------------------------------------------------------------
// Tree walker
// Sequencer that walks the tree with an explicit stack, pushing pending adds
// and rebuilding parent sums by read-modify-write on the two tree stores.
// ----------------------------------------------------------------------------
`default_nettype none

module lst_walk import lst_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire req_t              req_i,
  output logic                   ready_o,
  input  wire logic              out_free_i,
  output logic                   res_valid_o,
  output logic [DATA_W-1:0]      res_sum_o,
  output mem_req_t               mem_o,
  input  wire logic [DATA_W-1:0] sum_rd_i,
  input  wire logic [DATA_W-1:0] pend_rd_i
);

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_ENTER, ST_READ, ST_MUL, ST_PUSH, ST_CP0, ST_CP1, ST_CP2,
    ST_BODY, ST_RET, ST_RESUME, ST_PU0, ST_PU1, ST_PU2, ST_PU3, ST_PU4, ST_FIN
  } state_e;

  state_e            state_q;
  logic [ADDR_W-1:0] clr_q;
  req_e              kind_q;
  logic [IDX_W-1:0]  l_q, r_q;
  logic [DATA_W-1:0] v_q;
  logic [ADDR_W-1:0] node_q;
  logic [IDX_W-1:0]  lo_q, hi_q;
  logic [LVL_W-1:0]  depth_q;
  logic              ph_q;
  logic [IDX_W-1:0]  stk_lo_q [STACK_D];
  logic [IDX_W-1:0]  stk_hi_q [STACK_D];
  logic              stk_ph_q [STACK_D];
  logic [DATA_W-1:0] s_q, p_q, mul_q, cs_q, cp_q, cs2_q, cp2_q, tot_q, acc_q;

  logic [IDX_W-1:0]  span, mid, req_lo, req_hi;
  logic [CNT_W-1:0]  len, len_l, len_r, mul_b;
  logic [DATA_W-1:0] mul_a, prod;
  logic [ADDR_W-1:0] kid_l, kid_r;
  logic [LVL_W-1:0]  up_idx;
  logic              disjoint, full, leaf;

  assign span     = hi_q - lo_q;
  assign mid      = lo_q + {1'b0, span[IDX_W-1:1]};
  assign len      = {1'b0, hi_q} - {1'b0, lo_q} + CNT_W'(1);
  assign len_l    = {1'b0, mid} - {1'b0, lo_q} + CNT_W'(1);
  assign len_r    = {1'b0, hi_q} - {1'b0, mid};
  assign kid_l    = {node_q[ADDR_W-2:0], 1'b0};
  assign kid_r    = {node_q[ADDR_W-2:0], 1'b1};
  assign up_idx   = depth_q - LVL_W'(1);
  assign disjoint = (l_q > r_q) || (r_q < lo_q) || (l_q > hi_q);
  assign full     = (l_q <= lo_q) && (hi_q <= r_q);
  assign leaf     = (lo_q == hi_q);
  assign req_lo   = (req_i.lo > req_i.last) ? req_i.last : req_i.lo;
  assign req_hi   = (req_i.hi > req_i.last) ? req_i.last : req_i.hi;

  always_comb begin
    mul_a = p_q;
    mul_b = len;
    case (state_q)
      ST_PU2:  begin mul_a = cp_q;  mul_b = len_l; end
      ST_PU3:  begin mul_a = cp2_q; mul_b = len_r; end
      default: begin mul_a = p_q;   mul_b = len;   end
    endcase
  end

  assign prod = mul_a * {{(DATA_W-CNT_W){1'b0}}, mul_b};

  always_comb begin
    mem_o         = '0;
    mem_o.raddr   = node_q;
    mem_o.waddr   = node_q;
    unique case (state_q)
      ST_CLR: begin
        mem_o.waddr   = clr_q;
        mem_o.sum_we  = 1'b1;
        mem_o.pend_we = 1'b1;
      end
      ST_READ: begin
        mem_o.pend_we = (kind_q == REQ_ADD) && full;
        mem_o.pend_wd = pend_rd_i + v_q;
      end
      ST_PUSH: begin
        mem_o.sum_we  = 1'b1;
        mem_o.sum_wd  = s_q + mul_q;
        mem_o.pend_we = 1'b1;
      end
      ST_CP0: mem_o.raddr = kid_l;
      ST_CP1: begin
        mem_o.raddr   = kid_r;
        mem_o.waddr   = kid_l;
        mem_o.pend_we = 1'b1;
        mem_o.pend_wd = pend_rd_i + p_q;
      end
      ST_CP2: begin
        mem_o.waddr   = kid_r;
        mem_o.pend_we = 1'b1;
        mem_o.pend_wd = pend_rd_i + p_q;
      end
      ST_BODY: begin
        mem_o.sum_we  = (kind_q == REQ_SET) && leaf;
        mem_o.sum_wd  = v_q;
      end
      ST_PU0: mem_o.raddr = kid_l;
      ST_PU1: mem_o.raddr = kid_r;
      ST_PU4: begin
        mem_o.sum_we  = 1'b1;
        mem_o.sum_wd  = tot_q + cs2_q + mul_q;
      end
      default: mem_o.raddr = node_q;
    endcase
  end

  assign ready_o     = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_FIN) && out_free_i;
  assign res_sum_o   = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q   <= '0;
      kind_q  <= REQ_SET;
      l_q     <= '0;
      r_q     <= '0;
      v_q     <= '0;
      node_q  <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      depth_q <= '0;
      ph_q    <= 1'b0;
      s_q     <= '0;
      p_q     <= '0;
      mul_q   <= '0;
      cs_q    <= '0;
      cp_q    <= '0;
      cs2_q   <= '0;
      cp2_q   <= '0;
      tot_q   <= '0;
      acc_q   <= '0;
      for (int i = 0; i < STACK_D; i++) begin
        stk_lo_q[i] <= '0;
        stk_hi_q[i] <= '0;
        stk_ph_q[i] <= 1'b0;
      end
    end else begin
      unique case (state_q)
        ST_CLR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == ADDR_W'(TREE_SLOTS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start_i) begin
            kind_q  <= req_i.kind;
            l_q     <= req_lo;
            r_q     <= req_hi;
            v_q     <= req_i.val;
            node_q  <= ADDR_W'(1);
            lo_q    <= '0;
            hi_q    <= req_i.last;
            depth_q <= '0;
            acc_q   <= '0;
            if (req_i.kind == REQ_SET || req_i.kind == REQ_ADD ||
                req_i.kind == REQ_SUM) begin
              state_q <= ST_ENTER;
            end else begin
              state_q <= ST_RET;
            end
          end
        end
        ST_ENTER: begin
          if (kind_q != REQ_SET && disjoint) begin
            state_q <= ST_RET;
          end else begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          s_q <= sum_rd_i;
          p_q <= pend_rd_i;
          if (kind_q == REQ_ADD && full) begin
            state_q <= ST_RET;
          end else if (pend_rd_i != '0) begin
            state_q <= ST_MUL;
          end else begin
            state_q <= ST_BODY;
          end
        end
        ST_MUL: begin
          mul_q   <= prod;
          state_q <= ST_PUSH;
        end
        ST_PUSH: begin
          s_q     <= s_q + mul_q;
          state_q <= leaf ? ST_BODY : ST_CP0;
        end
        ST_CP0: state_q <= ST_CP1;
        ST_CP1: state_q <= ST_CP2;
        ST_CP2: state_q <= ST_BODY;
        ST_BODY: begin
          if ((kind_q == REQ_SUM && full) || (kind_q == REQ_SET && leaf)) begin
            if (kind_q == REQ_SUM) begin
              acc_q <= acc_q + s_q;
            end
            state_q <= ST_RET;
          end else begin
            stk_lo_q[depth_q] <= lo_q;
            stk_hi_q[depth_q] <= hi_q;
            depth_q           <= depth_q + LVL_W'(1);
            state_q           <= ST_ENTER;
            if (kind_q == REQ_SET && l_q > mid) begin
              stk_ph_q[depth_q] <= 1'b1;
              node_q            <= kid_r;
              lo_q              <= mid + IDX_W'(1);
            end else begin
              stk_ph_q[depth_q] <= 1'b0;
              node_q            <= kid_l;
              hi_q              <= mid;
            end
          end
        end
        ST_RET: begin
          if (depth_q == '0) begin
            state_q <= (kind_q == REQ_SUM) ? ST_FIN : ST_IDLE;
          end else begin
            node_q  <= {1'b0, node_q[ADDR_W-1:1]};
            lo_q    <= stk_lo_q[up_idx];
            hi_q    <= stk_hi_q[up_idx];
            ph_q    <= stk_ph_q[up_idx];
            depth_q <= up_idx;
            state_q <= ST_RESUME;
          end
        end
        ST_RESUME: begin
          if (kind_q != REQ_SET && !ph_q) begin
            stk_lo_q[depth_q] <= lo_q;
            stk_hi_q[depth_q] <= hi_q;
            stk_ph_q[depth_q] <= 1'b1;
            depth_q           <= depth_q + LVL_W'(1);
            node_q            <= kid_r;
            lo_q              <= mid + IDX_W'(1);
            state_q           <= ST_ENTER;
          end else if (kind_q == REQ_SUM) begin
            state_q <= ST_RET;
          end else begin
            state_q <= ST_PU0;
          end
        end
        ST_PU0: state_q <= ST_PU1;
        ST_PU1: begin
          cs_q    <= sum_rd_i;
          cp_q    <= pend_rd_i;
          state_q <= ST_PU2;
        end
        ST_PU2: begin
          cs2_q   <= sum_rd_i;
          cp2_q   <= pend_rd_i;
          mul_q   <= prod;
          state_q <= ST_PU3;
        end
        ST_PU3: begin
          tot_q   <= cs_q + mul_q;
          mul_q   <= prod;
          state_q <= ST_PU4;
        end
        ST_PU4: state_q <= ST_RET;
        ST_FIN: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/lazy_segment_tree_range_add.sv
// ----------------------------------------------------------------------------
// Lazy segment tree with point set, range add and range sum
// Sum tree over up to 1024 positions held in two RAMs (node sums and
// pending adds), with a configurable element count and a registered result.
// ----------------------------------------------------------------------------
//  Channel   Direction  Fields
//  s_axis    in         tuser: req_type; tdata: index_lo, index_hi, value
//  m_axis    out        tdata: range_sum
//  cfg       in         cfg_wdata_i: element_count
//
//  The walk visits one node at a time; the time spent at a node is set by the
//  registered RAM reads, the push of a pending add to the children and the
//  parent rebuild. After reset a clearing pass over all 2048 slots zeros both
//  RAMs; no item is accepted meanwhile. A finished sum waits while the output
//  register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module lazy_segment_tree_range_add import lst_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [55:0]      s_axis_tdata,  // index_lo, index_hi, value, zero pad
  input  wire logic [1:0]       s_axis_tuser,  // req_type
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [DATA_W-1:0]     m_axis_tdata,  // range_sum
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i
);

  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  last;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  logic              out_free, res_valid;
  logic [DATA_W-1:0] res_sum, sum_rd, pend_rd;
  req_t              req;
  mem_req_t          mem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_RESET;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (count_q == '0) begin
      last = '0;
    end else if (count_q > CNT_W'(NUM_ELEMENTS)) begin
      last = IDX_W'(NUM_ELEMENTS - 1);
    end else begin
      last = IDX_W'(count_q - CNT_W'(1));
    end
  end

  assign req.kind = req_e'(s_axis_tuser);
  assign req.lo   = s_axis_tdata[9:0];
  assign req.hi   = s_axis_tdata[19:10];
  assign req.val  = {{(DATA_W-VAL_W){s_axis_tdata[51]}}, s_axis_tdata[51:20]};
  assign req.last = last;

  assign out_free = !out_valid_q || m_axis_tready;

  lst_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid && s_axis_tready),
    .req_i       (req),
    .ready_o     (s_axis_tready),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_sum_o   (res_sum),
    .mem_o       (mem),
    .sum_rd_i    (sum_rd),
    .pend_rd_i   (pend_rd)
  );

  lst_ram #(.WIDTH(DATA_W), .DEPTH(TREE_SLOTS)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (mem.sum_we),
    .waddr_i (mem.waddr),
    .wdata_i (mem.sum_wd),
    .raddr_i (mem.raddr),
    .rdata_o (sum_rd)
  );

  lst_ram #(.WIDTH(DATA_W), .DEPTH(TREE_SLOTS)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (mem.pend_we),
    .waddr_i (mem.waddr),
    .wdata_i (mem.pend_wd),
    .raddr_i (mem.raddr),
    .rdata_o (pend_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res_sum;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

### src/lst_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the stream ports of the tree block for ordering and hold rules.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lazy_segment_tree_range_add_macros.svh"

module lst_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata
);

  `LST_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
  `LST_ASSERT_STABLE(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tdata, "result changed while stalled")
  `LST_ASSERT(a_busy_after_in, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready stayed high after a transaction")
  `LST_ASSERT(a_res_from_busy, clk_i, rst_ni, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result appeared while idle")

endmodule

bind lazy_segment_tree_range_add lst_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
